// ===== hdl/maf_pkg.sv =====
// maf_pkg: shared widths, defaults and reset values for the moving average filter
// used by moving_average_filter_unit and the testbench; depends on nothing else
package maf_pkg;

   // widths fixed by the transaction fields
   localparam int SAMPLE_W = 8;
   localparam int CFG_W    = 7;
   localparam int QUO_W    = 8;

   // default ring depth and window length after reset
   localparam int              WINDOW_MAX_DEFAULT  = 64;
   localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 7'd20;

endpackage

// ===== hdl/maf_ram.sv =====
// maf_ram: generic single write port, single read port ram with registered read data
// no dependencies
module maf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/moving_average_filter_unit.sv =====
// moving_average_filter_unit: simple moving average over the last window_length samples
// depends on maf_pkg and maf_ram
//
// Each accepted sample goes into a ring held in maf_ram and updates a running sum. Once a
// full window has arrived since reset or since the last write of csr_window_length, every
// sample gives one result, the window sum divided by the window length, truncated. A
// sample that fills no window is accepted, then goes through the ring read and sum update;
// a sample that gives a result goes on to a restoring divider that shifts the divisor
// right and the quotient in one bit a cycle, and then loads the result register.
// The result register lets the next sample in while a result
// waits on rsp_stall. A window length of 0 acts as 1, one above WINDOW_MAX as WINDOW_MAX.
// Any write of csr_window_length, even of the same value, restarts the window; it must
// only be written while the block is idle.
module moving_average_filter_unit #(
   parameter int WINDOW_MAX = maf_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // input transaction
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [maf_pkg::SAMPLE_W-1:0] req_sample,
   // result transaction
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [maf_pkg::SAMPLE_W-1:0] rsp_average,
   // window length register
   input  logic                       csr_write_enable,
   input  logic [maf_pkg::CFG_W-1:0]  csr_window_length
);

   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int SUM_W = $clog2(WINDOW_MAX * 255 + 1);
   localparam int DW    = LEN_W + maf_pkg::QUO_W;
   localparam int CNT_W = $clog2(maf_pkg::QUO_W);
   localparam int CW    = (maf_pkg::CFG_W > LEN_W) ? maf_pkg::CFG_W : LEN_W;
   localparam int SW    = maf_pkg::SAMPLE_W;
   localparam int QW    = maf_pkg::QUO_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [PTR_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    filled_ff, filled_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SW-1:0]       sample_ff, sample_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [DW-1:0]       div_ff, div_in;
   logic [QW-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]       rsp_average_ff, rsp_average_in;

   logic                req_take;
   logic                rsp_taken;
   logic [SW-1:0]       ring_rd_data;
   logic                ram_wr_en;
   logic                was_full;
   logic [SUM_W-1:0]    new_sum;
   logic [PTR_W-1:0]    pos_next;
   logic                rem_ge;

   // window length as used: zero acts as one, saturate at the ring depth
   function automatic logic [LEN_W-1:0] clamp_len(logic [maf_pkg::CFG_W-1:0] v);
      logic [CW-1:0] ext;
      ext = CW'(v);
      if (ext == '0) begin
         return LEN_W'(1);
      end else if (ext > CW'(WINDOW_MAX)) begin
         return LEN_W'(WINDOW_MAX);
      end else begin
         return LEN_W'(ext);
      end
   endfunction

   // handshakes, no input transaction while the window length is written
   assign req_stall   = (state_ff != ST_IDLE) || csr_write_enable;
   assign req_take    = req_valid && !req_stall;
   assign rsp_taken   = rsp_valid_ff && !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   // ring write happens once the old entry has been read
   assign ram_wr_en = (state_ff == ST_UPDATE);

   maf_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (req_take),
      .rd_addr (pos_ff),
      .rd_data (ring_rd_data)
   );

   // running sum and ring position update
   assign was_full = (filled_ff >= len_ff);
   assign new_sum  = was_full ? (sum_ff - SUM_W'(ring_rd_data) + SUM_W'(sample_ff))
                              : (sum_ff + SUM_W'(sample_ff));
   assign pos_next = (LEN_W'(pos_ff) + LEN_W'(1) == len_ff) ? '0 : (pos_ff + PTR_W'(1));

   // restoring divider step
   assign rem_ge = (rem_ff >= div_ff);

   // next state logic
   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      pos_in         = pos_ff;
      filled_in      = filled_ff;
      sum_in         = sum_ff;
      sample_in      = sample_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_taken ? 1'b0 : rsp_valid_ff;
      rsp_average_in = rsp_average_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_write_enable) begin
               len_in    = clamp_len(csr_window_length);
               pos_in    = '0;
               filled_in = '0;
               sum_in    = '0;
            end else if (req_take) begin
               sample_in = req_sample;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            sum_in = new_sum;
            pos_in = pos_next;
            rem_in = DW'(new_sum);
            div_in = DW'({len_ff, {(QW-1){1'b0}}});
            cnt_in = CNT_W'(QW - 1);
            if (was_full) begin
               state_in = ST_DIVIDE;
            end else begin
               filled_in = filled_ff + LEN_W'(1);
               state_in  = (filled_ff + LEN_W'(1) == len_ff) ? ST_DIVIDE : ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            rem_in = rem_ge ? (rem_ff - div_ff) : rem_ff;
            quo_in = {quo_ff[QW-2:0], rem_ge};
            div_in = div_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_DELIVER;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = quo_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= clamp_len(maf_pkg::WINDOW_LENGTH_RESET);
         pos_ff       <= '0;
         filled_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         filled_ff    <= filled_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      rsp_average_ff <= rsp_average_in;
   end

   // the window never holds more samples than its length
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= len_ff)
      else $error("filled count above window length");

   // the ring position stays inside the window
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(pos_ff) < len_ff)
      else $error("ring position outside window");

   // a division is only started on a full window
   a_divide_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (filled_ff == len_ff))
      else $error("division on a partial window");

   // the remainder always fits the quotient bits still to come
   a_rem_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> ({1'b0, rem_ff} < {div_ff, 1'b0}))
      else $error("quotient overflow in divider");

   // a result is loaded only from the deliver state
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DELIVER))
      else $error("result loaded outside deliver state");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for moving_average_filter_unit
// depends on maf_pkg and the filter rtl; checks each average against its own window model

module testbench;

   localparam int SAMPLE_W      = maf_pkg::SAMPLE_W;
   localparam int CFG_W         = maf_pkg::CFG_W;
   localparam int QUO_W         = maf_pkg::QUO_W;
   localparam int WINDOW_MAX    = maf_pkg::WINDOW_MAX_DEFAULT;
   localparam int POS_W         = $clog2(WINDOW_MAX);
   localparam int FILL_W        = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W         = SAMPLE_W + $clog2(WINDOW_MAX);
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int LONG_HOLD     = 600;
   localparam int CYCLE_LIMIT   = 400_000;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [SAMPLE_W-1:0] value;
      int                  count;
      bit                  typed;
      logic [QUO_W-1:0]    want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [SAMPLE_W-1:0] rsp_average;
   logic                csr_write_enable;
   logic [CFG_W-1:0]    csr_window_length;

   // window model
   logic [SAMPLE_W-1:0] model_ring [WINDOW_MAX];
   logic [POS_W-1:0]    model_pos;
   logic [FILL_W-1:0]   model_fill;
   logic [SUM_W-1:0]    model_sum;
   logic [CFG_W-1:0]    model_len;

   logic [QUO_W-1:0]    pending_averages [$];
   logic [QUO_W-1:0]    oldest_average;
   int                  mismatches = 0;
   int                  cycle_count = 0;
   int                  samples_sent = 0;
   int                  averages_seen = 0;
   bit                  send_calm = 1'b0;
   bit                  recv_calm = 1'b0;
   bit                  hold_request = 1'b0;

   moving_average_filter_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .csr_write_enable  (csr_write_enable),
      .csr_window_length (csr_window_length)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   // window length write restarts the window
   task automatic restart_model(input logic [CFG_W-1:0] len);
      model_len  = len;
      model_pos  = '0;
      model_fill = '0;
      model_sum  = '0;
   endtask

   // one sample into the window model; mean valid only once the window is full
   task automatic slide_window(input logic [SAMPLE_W-1:0] s, output bit produced,
                               output logic [QUO_W-1:0] mean);
      int span;
      span = (model_len == 0) ? 1 : ((model_len > WINDOW_MAX) ? WINDOW_MAX : model_len);
      if (model_pos >= span)
         model_pos = '0;
      if (model_fill >= span)
         model_sum = model_sum - model_ring[model_pos];
      else
         model_fill = model_fill + 1'b1;
      model_sum = model_sum + s;
      model_ring[model_pos] = s;
      model_pos = (model_pos + 1 >= span) ? '0 : model_pos + 1'b1;
      produced = (model_fill >= span);
      mean = QUO_W'(model_sum / span);
   endtask

   // offer one sample after a random gap and wait for the transaction
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, output bit produced,
                              output logic [QUO_W-1:0] mean);
      int gap;
      gap = draw_wait(send_calm);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      slide_window(s, produced, mean);
      samples_sent++;
      if (samples_sent % 64 == 0)
         send_calm = ($urandom_range(0, 3) == 0);
   endtask

   // write the window length once the block has drained
   task automatic write_window(input logic [CFG_W-1:0] len);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_averages.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable  <= 1'b1;
      csr_window_length <= len;
      @(negedge clock);
      csr_write_enable  <= 1'b0;
      restart_model(len);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_averages.size() == 0) begin
            report_mismatch($sformatf("average %0d with nothing expected", rsp_average));
         end else begin
            oldest_average = pending_averages.pop_front();
            if (rsp_average !== oldest_average)
               report_mismatch($sformatf("average %0d, expected %0d",
                                         rsp_average, oldest_average));
         end
         averages_seen <= averages_seen + 1;
      end
   end

   // result side stall, with one long hold-off on request
   initial begin
      int wait_cycles;
      int taken;
      rsp_stall = 1'b0;
      taken = 0;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            wait_cycles  = LONG_HOLD;
         end else begin
            wait_cycles = draw_wait(recv_calm);
         end
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if (taken % 64 == 0)
            recv_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // stimulus
   initial begin
      stim_row_type        rows [$];
      bit                  produced;
      logic [QUO_W-1:0]    mean;
      logic [SAMPLE_W-1:0] s;
      logic [CFG_W-1:0]    len;
      int                  span;
      int                  phase_items;
      int                  random_sent;
      bit                  hold_done;
      bit                  pause_done;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample        = '0;
      csr_write_enable  = 1'b0;
      csr_window_length = '0;
      restart_model(maf_pkg::WINDOW_LENGTH_RESET);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: reset window of 20, zero length, restart on rewrite of the same length
      rows.push_back(stim_row_type'{ROW_SAMPLE, 8'd255, 20, 1'b1, 8'd255});
      rows.push_back(stim_row_type'{ROW_SAMPLE, 8'd0,   1,  1'b1, 8'd242});
      rows.push_back(stim_row_type'{ROW_WRITE,  8'd0,   1,  1'b0, 8'd0});
      rows.push_back(stim_row_type'{ROW_SAMPLE, 8'd170, 1,  1'b1, 8'd170});
      rows.push_back(stim_row_type'{ROW_WRITE,  8'd2,   1,  1'b0, 8'd0});
      rows.push_back(stim_row_type'{ROW_SAMPLE, 8'd255, 1,  1'b0, 8'd0});
      rows.push_back(stim_row_type'{ROW_SAMPLE, 8'd1,   1,  1'b1, 8'd128});
      rows.push_back(stim_row_type'{ROW_WRITE,  8'd2,   1,  1'b0, 8'd0});
      rows.push_back(stim_row_type'{ROW_SAMPLE, 8'd85,  1,  1'b0, 8'd0});

      foreach (rows[r]) begin
         if (rows[r].kind == ROW_WRITE) begin
            write_window(rows[r].value[CFG_W-1:0]);
         end else begin
            repeat (rows[r].count) begin
               send_sample(rows[r].value, produced, mean);
               if (produced)
                  pending_averages.push_back(rows[r].typed ? rows[r].want : mean);
            end
         end
      end

      // random phases, each under one window length
      random_sent = 0;
      hold_done   = 1'b0;
      pause_done  = 1'b0;
      while (random_sent < RANDOM_ITEMS) begin
         if (!hold_done && random_sent >= 600) begin
            // short window so results pile up behind the long hold-off
            write_window(7'd3);
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end else if (!pause_done && random_sent >= 1000) begin
            // sender pause until the block has delivered everything
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_averages.size() != 0)
               @(posedge clock);
            pause_done = 1'b1;
         end else if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 9))
               0:       len = 7'd0;
               1:       len = 7'd1;
               2:       len = 7'd64;
               3:       len = 7'($urandom_range(65, 127));
               4:       len = 7'd127;
               5, 6:    len = 7'($urandom_range(2, 8));
               default: len = 7'($urandom_range(1, 63));
            endcase
            write_window(len);
         end
         span = (model_len == 0) ? 1 :
                ((model_len > WINDOW_MAX) ? WINDOW_MAX : model_len);
         phase_items = span + $urandom_range(4, 40);
         repeat (phase_items) begin
            case ($urandom_range(0, 7))
               0:       s = '0;
               1:       s = '1;
               default: s = SAMPLE_W'($urandom_range(0, 255));
            endcase
            send_sample(s, produced, mean);
            if (produced)
               pending_averages.push_back(mean);
            random_sent++;
         end
      end

      // drain and finish
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_averages.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
